[src/swsfr_pkg.sv]
package swsfr_pkg;

  // link status codes as seen on the result word
  typedef enum logic [2:0] {
    LINK_CONNECTING   = 3'd0,
    LINK_READING      = 3'd1,
    LINK_OK           = 3'd2,
    LINK_CHECK_ERROR  = 3'd3,
    LINK_DISCONNECTED = 3'd4
  } link_state_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BIT_THRESHOLD  = 2'd0,
    REG_PREAMBLE_EDGES = 2'd1,
    REG_START_TICK     = 2'd2,
    REG_WRAP_TICK      = 2'd3
  } cfg_reg_t;

  localparam int TICK_W     = 14;
  localparam int INTERVAL_W = 10;
  localparam int PREAMBLE_W = 3;
  localparam int EDGE_W     = 6;
  localparam int DATA_W     = 32;
  localparam int CHECK_W    = 8;
  localparam int VALUE_W    = 16;
  localparam int CFG_DATA_W = 14;

  // frame layout, counted from the first data edge
  localparam logic [EDGE_W:0] DATA_EDGES  = 7'd32;
  localparam logic [EDGE_W:0] FRAME_EDGES = 7'd40;
  localparam logic [EDGE_W:0] LAST_EDGE   = 7'd39;

  localparam logic [INTERVAL_W-1:0] THRESHOLD_RESET = 10'd100;
  localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET  = 3'd2;
  localparam logic [TICK_W-1:0]     START_RESET     = 14'd2500;
  localparam logic [TICK_W-1:0]     WRAP_RESET      = 14'd9000;

  // low byte of the sum of the four data bytes
  function automatic logic [CHECK_W-1:0] byte_sum(input logic [DATA_W-1:0] d);
    byte_sum = d[7:0] + d[15:8] + d[23:16] + d[31:24];
  endfunction

  // sign-magnitude temperature to two's complement
  function automatic logic [VALUE_W-1:0] sm_to_twos(input logic [VALUE_W-1:0] d);
    logic [VALUE_W-1:0] mag;
    mag = {1'b0, d[VALUE_W-2:0]};
    sm_to_twos = d[VALUE_W-1] ? (~mag + 16'd1) : mag;
  endfunction

endpackage

[src/single_wire_sensor_frame_receiver_core.sv]
// channel  | handshake              | word
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_stall    | kind, interval_us
// out      | out_valid / out_stall  | line_low, link_status, humidity_tenths,
//          |                        | temperature_tenths, frame_done
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one word in, one word out; a word passes through the input register, then
// the decode and state update into the output register
// a new word is taken every cycle while out is not stalled; the input register
// and output register together hold two words under a stall
// rst is synchronous active high: config returns to its defaults, link goes to
// connecting, counters, shift bits and decoded values clear; cfg_ready is always
// high; the user has registers written only while the block is idle (unenforced)
module single_wire_sensor_frame_receiver_core
  import swsfr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [INTERVAL_W-1:0]        interval_us,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         line_low,
  output logic [2:0]                   link_status,
  output logic [VALUE_W-1:0]           humidity_tenths,
  output logic signed [VALUE_W-1:0]    temperature_tenths,
  output logic                         frame_done,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // configuration registers
  logic [INTERVAL_W-1:0] bit_threshold_us;
  logic [PREAMBLE_W-1:0] preamble_edges;
  logic [TICK_W-1:0]     start_tick;
  logic [TICK_W-1:0]     wrap_tick;

  // input register
  logic                  stage_valid;
  logic                  stage_kind;
  logic [INTERVAL_W-1:0] stage_interval;

  // receiver state
  logic [TICK_W-1:0]     tick_count,        tick_count_next;
  logic [EDGE_W-1:0]     edge_index,        edge_index_next;
  logic [DATA_W-1:0]     data_bits,         data_bits_next;
  logic [CHECK_W-1:0]    check_bits,        check_bits_next;
  link_state_t           link_state,        link_state_next;
  logic [VALUE_W-1:0]    humidity_value,    humidity_value_next;
  logic [VALUE_W-1:0]    temperature_value, temperature_value_next;
  logic                  drive_low,         drive_low_next;
  logic                  done_next;

  logic                  stage_adv;
  logic                  in_take;

  // working values for the decode
  logic [TICK_W:0]       tick_inc;
  logic [TICK_W:0]       tick_wrapped;
  logic [TICK_W:0]       start_ext;
  logic                  edge_bit;
  logic [EDGE_W:0]       offset;
  logic                  past_preamble;
  logic [EDGE_W:0]       frame_end;
  logic [EDGE_W-1:0]     index_inc;

  // handshakes: the stage moves whenever the output register is free or drained
  assign stage_adv = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !stage_adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold_us <= THRESHOLD_RESET;
      preamble_edges   <= PREAMBLE_RESET;
      start_tick       <= START_RESET;
      wrap_tick        <= WRAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIT_THRESHOLD:  bit_threshold_us <= cfg_data[INTERVAL_W-1:0];
        REG_PREAMBLE_EDGES: preamble_edges   <= cfg_data[PREAMBLE_W-1:0];
        REG_START_TICK:     start_tick       <= cfg_data[TICK_W-1:0];
        REG_WRAP_TICK:      wrap_tick        <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (stage_adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_kind     <= kind;
      stage_interval <= interval_us;
    end
  end

  // decode of one word against the current state
  always_comb begin
    tick_count_next        = tick_count;
    edge_index_next        = edge_index;
    data_bits_next         = data_bits;
    check_bits_next        = check_bits;
    link_state_next        = link_state;
    humidity_value_next    = humidity_value;
    temperature_value_next = temperature_value;
    drive_low_next         = drive_low;
    done_next              = 1'b0;

    tick_inc      = {1'b0, tick_count} + 15'd1;
    tick_wrapped  = (tick_inc > {1'b0, wrap_tick}) ? '0 : tick_inc;
    start_ext     = {1'b0, start_tick};
    edge_bit      = stage_interval > bit_threshold_us;
    past_preamble = edge_index >= {3'b000, preamble_edges};
    offset        = {1'b0, edge_index} - {4'b0000, preamble_edges};
    frame_end     = {4'b0000, preamble_edges} + LAST_EDGE;
    index_inc     = edge_index + 6'd1;

    if (!stage_kind) begin
      // millisecond tick: wrap, start pulse window, missing sensor
      tick_count_next = tick_wrapped[TICK_W-1:0];
      if (tick_wrapped > start_ext + 15'd1) begin
        edge_index_next = '0;
        drive_low_next  = 1'b0;
      end else if (tick_wrapped >= start_ext) begin
        data_bits_next  = '0;
        check_bits_next = '0;
        drive_low_next  = 1'b1;
        edge_index_next = '0;
      end
      if (link_state == LINK_READING) begin
        link_state_next = LINK_DISCONNECTED;
      end
    end else begin
      // falling edge: class the bit and shift it in msb first
      link_state_next = LINK_READING;
      if (past_preamble && offset < DATA_EDGES) begin
        data_bits_next[5'd31 - offset[4:0]] = data_bits[5'd31 - offset[4:0]] | edge_bit;
      end
      if (past_preamble && offset >= DATA_EDGES && offset < FRAME_EDGES) begin
        check_bits_next[3'd7 - offset[2:0]] = check_bits[3'd7 - offset[2:0]] | edge_bit;
        if (offset == LAST_EDGE) begin
          tick_count_next = '0;
          done_next       = 1'b1;
          if (byte_sum(data_bits_next) == check_bits_next) begin
            link_state_next        = LINK_OK;
            humidity_value_next    = data_bits_next[31:16];
            temperature_value_next = sm_to_twos(data_bits_next[15:0]);
          end else begin
            link_state_next = LINK_CHECK_ERROR;
          end
        end
      end
      edge_index_next = ({1'b0, index_inc} > frame_end) ? '0 : index_inc;
    end
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count        <= '0;
      edge_index        <= '0;
      data_bits         <= '0;
      check_bits        <= '0;
      link_state        <= LINK_CONNECTING;
      humidity_value    <= '0;
      temperature_value <= '0;
      drive_low         <= 1'b0;
    end else if (stage_adv) begin
      tick_count        <= tick_count_next;
      edge_index        <= edge_index_next;
      data_bits         <= data_bits_next;
      check_bits        <= check_bits_next;
      link_state        <= link_state_next;
      humidity_value    <= humidity_value_next;
      temperature_value <= temperature_value_next;
      drive_low         <= drive_low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      line_low           <= drive_low_next;
      link_status        <= link_state_next;
      humidity_tenths    <= humidity_value_next;
      temperature_tenths <= signed'(temperature_value_next);
      frame_done         <= done_next;
    end
  end

`ifndef SYNTHESIS
  // a completed frame always reports a checksum verdict
  a_done_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |->
      (link_status == LINK_OK || link_status == LINK_CHECK_ERROR))
    else $error("frame_done without checksum verdict");

  // the edge counter never runs past the longest frame
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_index <= 6'd46)
    else $error("edge_index out of range");

  // completing a frame restarts the tick counter
  a_done_tick: assert property (@(posedge clk) disable iff (rst)
    stage_adv && done_next |=> tick_count == '0)
    else $error("tick_count not cleared at frame end");

  // the start pulse only begins on a tick
  a_drive_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(drive_low) |-> $past(stage_adv && !stage_kind))
    else $error("line driven low outside a tick");

  // a stalled input only while both registers are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

[dv/single_wire_sensor_frame_receiver_core_test.sv]
`timescale 1ns / 1ps

// checks the single-wire sensor frame receiver word by word against a local
// model of its tick counter, edge classer, shift registers and decoder
module single_wire_sensor_frame_receiver_core_test;
  import swsfr_pkg::*;

  // input word kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  // receiver hold-off for the back-pressure test
  localparam int HOLD_CYCLES = 300;
  // cycles with no handshake at all before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // cycles to wait after the last result, two-stage pipe plus margin
  localparam int TAIL_CYCLES = 8;

  // one result word as predicted
  typedef struct packed {
    logic               line_low;
    logic [2:0]         link_status;
    logic [VALUE_W-1:0] humidity;
    logic [VALUE_W-1:0] temperature;
    logic               done;
  } sensor_word_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      kind;
  logic [INTERVAL_W-1:0]     interval_us;
  logic                      out_valid;
  logic                      out_stall;
  logic                      line_low;
  logic [2:0]                link_status;
  logic [VALUE_W-1:0]        humidity_tenths;
  logic signed [VALUE_W-1:0] temperature_tenths;
  logic                      frame_done;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // shadow of the configuration registers
  logic [INTERVAL_W-1:0] thr_us;
  logic [PREAMBLE_W-1:0] pre_edges;
  logic [TICK_W-1:0]     start_at;
  logic [TICK_W-1:0]     wrap_at;

  // model of the receiver state
  logic [TICK_W-1:0]  tick_cnt;
  logic [EDGE_W-1:0]  edge_pos;
  logic [DATA_W-1:0]  data_shift;
  logic [CHECK_W-1:0] check_shift;
  link_state_t        link_now;
  logic [VALUE_W-1:0] hum_good;
  logic [VALUE_W-1:0] temp_good;
  logic               host_low;

  sensor_word_t pending_words[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int items_sent;
  int mismatches;

  single_wire_sensor_frame_receiver_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .kind               (kind),
    .interval_us        (interval_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .line_low           (line_low),
    .link_status        (link_status),
    .humidity_tenths    (humidity_tenths),
    .temperature_tenths (temperature_tenths),
    .frame_done         (frame_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // model of one input word; updates the local state and gives the result word
  // ---------------------------------------------------------------------------
  task automatic predict_word(input logic k, input logic [INTERVAL_W-1:0] iv,
                              output sensor_word_t w);
    logic [TICK_W:0]    nxt;
    logic               bit_val;
    int                 p;
    int                 i;
    logic [CHECK_W-1:0] sum;
    w = '0;
    if (k == KIND_TICK) begin
      // the next count is one bit wider so a count of 16383 can wrap
      nxt = {1'b0, tick_cnt} + 1'b1;
      if (nxt > {1'b0, wrap_at}) nxt = '0;
      tick_cnt = nxt[TICK_W-1:0];
      if (int'(nxt) > int'(start_at) + 1) begin
        // past the start pulse: release the line
        edge_pos = '0;
        host_low = 1'b0;
      end else if (nxt >= {1'b0, start_at}) begin
        // start pulse: the only place the shift bits are cleared
        data_shift  = '0;
        check_shift = '0;
        host_low    = 1'b1;
        edge_pos    = '0;
      end
      // a tick in the middle of a frame means the sensor went quiet
      if (link_now == LINK_READING) link_now = LINK_DISCONNECTED;
    end else begin
      bit_val  = (iv > thr_us);
      p        = int'(pre_edges);
      i        = int'(edge_pos);
      link_now = LINK_READING;
      // bits are only ORed in, MSB first
      if (i >= p && i < p + 32) data_shift[31 + p - i] |= bit_val;
      if (i >= p + 32 && i < p + 40) begin
        check_shift[39 + p - i] |= bit_val;
        if (i == p + 39) begin
          tick_cnt = '0;
          w.done   = 1'b1;
          sum = data_shift[31:24] + data_shift[23:16] + data_shift[15:8] + data_shift[7:0];
          if (sum == check_shift) begin
            link_now = LINK_OK;
            hum_good = data_shift[31:16];
            // sign-magnitude temperature to two's complement
            temp_good = data_shift[15] ? (16'd0 - {1'b0, data_shift[14:0]})
                                       : {1'b0, data_shift[14:0]};
          end else begin
            link_now = LINK_CHECK_ERROR;
          end
        end
      end
      // an index already past the frame (preamble shrunk mid-frame) wraps too
      i = i + 1;
      if (i > p + 39) i = 0;
      edge_pos = EDGE_W'(i);
    end
    w.line_low    = host_low;
    w.link_status = link_now;
    w.humidity    = hum_good;
    w.temperature = temp_good;
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers one word, keeps valid up when the next word follows at once
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic k, input logic [INTERVAL_W-1:0] iv);
    sensor_word_t w;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    interval_us <= iv;
    do @(posedge clk); while (in_stall);
    predict_word(k, iv, w);
    pending_words.push_back(w);
    items_sent++;
  endtask

  // drop valid and wait until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BIT_THRESHOLD:  thr_us    = value[INTERVAL_W-1:0];
      REG_PREAMBLE_EDGES: pre_edges = value[PREAMBLE_W-1:0];
      REG_START_TICK:     start_at  = value;
      REG_WRAP_TICK:      wrap_at   = value;
      default: ;
    endcase
  endtask

  // 40-bit frame with byte-sum check, optionally spoiled
  function automatic logic [39:0] build_frame(input logic [15:0] hum,
                                              input logic [15:0] temp_sm,
                                              input logic corrupt);
    logic [7:0] chk;
    chk = hum[15:8] + hum[7:0] + temp_sm[15:8] + temp_sm[7:0];
    if (corrupt) chk = chk ^ 8'($urandom_range(255, 1));
    return {hum, temp_sm, chk};
  endfunction

  // edge interval that decodes to the wanted bit under the current threshold
  function automatic logic [INTERVAL_W-1:0] bit_interval(input logic b);
    if (b && thr_us != '1) return INTERVAL_W'($urandom_range(1023, int'(thr_us) + 1));
    else if (b) return '1;
    else return INTERVAL_W'($urandom_range(int'(thr_us), 0));
  endfunction

  // preamble edges, then the first n_bits of the frame
  task automatic send_frame(input logic [39:0] frame, input int n_bits);
    for (int j = 0; j < int'(pre_edges); j++) send_word(KIND_EDGE, INTERVAL_W'($urandom));
    for (int j = 0; j < n_bits; j++) send_word(KIND_EDGE, bit_interval(frame[39 - j]));
  endtask

  // ticks until the line has been pulled low and released again
  task automatic start_pulse();
    int   guard;
    logic went_low;
    guard    = 2 * (int'(wrap_at) + 3);
    went_low = 1'b0;
    while (guard > 0) begin
      send_word(KIND_TICK, INTERVAL_W'($urandom));
      if (host_low) went_low = 1'b1;
      else if (went_low) break;
      guard--;
    end
  endtask

  // random but usable settings: small tick counts keep frames frequent
  task automatic pick_settings();
    int r;
    int st;
    r = $urandom_range(9);
    if (r == 0) write_reg(REG_BIT_THRESHOLD, '0);
    else if (r == 1) write_reg(REG_BIT_THRESHOLD, 14'd1023);
    else write_reg(REG_BIT_THRESHOLD, CFG_DATA_W'($urandom_range(900, 50)));
    write_reg(REG_PREAMBLE_EDGES, CFG_DATA_W'($urandom_range(7, 0)));
    st = $urandom_range(8, 1);
    write_reg(REG_START_TICK, CFG_DATA_W'(st));
    // at least start + 2 so the pulse always ends
    write_reg(REG_WRAP_TICK, CFG_DATA_W'(st + $urandom_range(12, 2)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a clean frame straight out of reset with default settings, extreme values
  task automatic test_reset_frame();
    send_idle_pct = 20;
    recv_idle_pct = 30;
    send_word(KIND_TICK, '0);
    // full-scale humidity, most negative temperature
    send_frame(build_frame(16'hffff, 16'hffff, 1'b0), 40);
    send_word(KIND_TICK, '1);
  endtask

  // tick counter corners, threshold extremes, preamble shrunk mid-frame
  task automatic test_corner_cases();
    send_idle_pct = 20;
    recv_idle_pct = 30;
    // wrap below the legal range: at one the count alternates, at zero every tick lands on zero
    write_reg(REG_WRAP_TICK, 14'd1);
    write_reg(REG_START_TICK, 14'd1);
    repeat (3) send_word(KIND_TICK, INTERVAL_W'($urandom));
    write_reg(REG_WRAP_TICK, 14'd0);
    repeat (2) send_word(KIND_TICK, INTERVAL_W'($urandom));
    // start beyond wrap: the start pulse never comes
    write_reg(REG_START_TICK, 14'd16383);
    write_reg(REG_WRAP_TICK, 14'd2);
    repeat (4) send_word(KIND_TICK, INTERVAL_W'($urandom));
    // wrap just one above start: the line stays low once pulled
    write_reg(REG_START_TICK, 14'd1);
    repeat (3) send_word(KIND_TICK, INTERVAL_W'($urandom));
    write_reg(REG_START_TICK, 14'd2);
    write_reg(REG_WRAP_TICK, 14'd16383);
    start_pulse();
    // threshold zero: only a zero interval is a zero bit
    write_reg(REG_BIT_THRESHOLD, 14'd0);
    write_reg(REG_PREAMBLE_EDGES, 14'd7);
    for (int j = 0; j < 41; j++)
      send_word(KIND_EDGE, (j % 3 == 0) ? 10'd0 : ((j % 3 == 1) ? 10'd1 : 10'h3ff));
    // index is now past the shorter frame: next edge stores nothing and wraps
    write_reg(REG_PREAMBLE_EDGES, 14'd0);
    send_word(KIND_EDGE, 10'h3ff);
    // threshold at the top: nothing decodes as one
    write_reg(REG_BIT_THRESHOLD, 14'd1023);
    send_word(KIND_EDGE, 10'h3ff);
    send_word(KIND_EDGE, 10'd0);
    // tick while reading marks the sensor disconnected
    send_word(KIND_TICK, 10'h155);
    send_word(KIND_TICK, 10'h2aa);
  endtask

  // mostly whole frames with random content, some broken ones and noise
  task automatic test_random_traffic(input int s_pct, input int r_pct, input int quota);
    int first;
    int r;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    first = items_sent;
    pick_settings();
    while (items_sent - first < quota) begin
      if ($urandom_range(99) < 12) pick_settings();
      r = $urandom_range(99);
      if (r < 70) begin
        start_pulse();
        send_frame(build_frame(16'($urandom), 16'($urandom), $urandom_range(99) < 15), 40);
      end else if (r < 82) begin
        // frame cut short, often followed by a tick
        start_pulse();
        send_frame(build_frame(16'($urandom), 16'($urandom), 1'b0), $urandom_range(39, 1));
        if ($urandom_range(1)) send_word(KIND_TICK, INTERVAL_W'($urandom));
      end else if (r < 90) begin
        // no start pulse: new bits pile onto the old ones
        send_frame(build_frame(16'($urandom), 16'($urandom), 1'($urandom_range(1))), 40);
      end else begin
        repeat ($urandom_range(6, 1)) send_word(1'($urandom), INTERVAL_W'($urandom));
      end
    end
  endtask

  // receiver holds off for a long time while words keep coming
  task automatic test_stall_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    start_pulse();
    send_frame(build_frame(16'($urandom), 16'($urandom), 1'b0), 40);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checker: random stall, long hold on request
  // ---------------------------------------------------------------------------
  task automatic check_word();
    sensor_word_t exp_w;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: line_low=%0b link=%0d hum=%0d temp=%0d done=%0b",
                 line_low, link_status, humidity_tenths, temperature_tenths, frame_done);
      return;
    end
    exp_w = pending_words.pop_front();
    if (line_low !== exp_w.line_low || link_status !== exp_w.link_status ||
        humidity_tenths !== exp_w.humidity || temperature_tenths !== exp_w.temperature ||
        frame_done !== exp_w.done) begin
      mismatches++;
      if (mismatches <= 10)
        $display(
          "mismatch %0t exp/act: low %0b/%0b link %0d/%0d hum %0d/%0d temp %0d/%0d done %0b/%0b",
          $realtime, exp_w.line_low, line_low, exp_w.link_status, link_status,
          exp_w.humidity, humidity_tenths, $signed(exp_w.temperature),
          temperature_tenths, exp_w.done, frame_done);
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_word();
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // hang detector: any handshake restarts the count
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= HANG_LIMIT) begin
        $display("no handshake for %0d cycles", HANG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid      <= 1'b0;
    kind          <= KIND_TICK;
    interval_us   <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_BIT_THRESHOLD;
    cfg_data      <= '0;
    rst           <= 1'b1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    items_sent    = 0;
    mismatches    = 0;
    // model state after reset
    thr_us      = THRESHOLD_RESET;
    pre_edges   = PREAMBLE_RESET;
    start_at    = START_RESET;
    wrap_at     = WRAP_RESET;
    tick_cnt    = '0;
    edge_pos    = '0;
    data_shift  = '0;
    check_shift = '0;
    link_now    = LINK_CONNECTING;
    hum_good    = '0;
    temp_good   = '0;
    host_low    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_frame();
    test_corner_cases();
    test_random_traffic(36, 64, 300);
    test_random_traffic(64, 36, 300);
    test_random_traffic(0, 0, 300);
    test_stall_pressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
